// ----- sv/dehq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dehq_pkg
// Shared types and constants for the digital input edge event qualifier:
// port count, field widths, mode codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
package dehq_pkg;

    // Number of ports that carry a lane; the fire mask is always FIRE_W bits.
    localparam int NUM_PORTS = 4;
    localparam int FIRE_W    = 4;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 22;
    localparam int MODES_W  = 8;
    localparam int CFG_IDX_W = 3;

    // Timing constants in microseconds.
    localparam logic [TIME_W-1:0] US_PER_MS = 32'd1000;
    localparam logic [TIME_W:0]   SLACK_US  = 33'd24000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_MODES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_PORT0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_PORT3 = 3'd4;

    // Edge selection per port.
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_FALL = 2'd1,
        MODE_RISE = 2'd2,
        MODE_ANY  = 2'd3
    } t_mode;

    // Per-lane settings: edge mode and the hold time already scaled to
    // microseconds (zero means fire at once).
    typedef struct packed {
        t_mode             mode;
        logic [TIME_W-1:0] need_us;
    } t_lane_cfg;

endpackage

// ----- sv/dehq_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dehq_lane
// One port's edge detector: tracks the last level, arms on the selected edge,
// and fires once the hold time (less the slack) has elapsed (at once if zero).
// ----------------------------------------------------------------------------
module dehq_lane
    import dehq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_lane_cfg         i_cfg,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_now_us,
    output logic              o_fire
);

    logic              r_last;
    logic              r_armed;
    logic [TIME_W-1:0] r_start;
    logic              n_last;
    logic              n_armed;
    logic [TIME_W-1:0] n_start;

    logic              w_changed;
    logic              w_edge_ok;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_hold_done;

    // Edge qualification against the selected mode.
    assign w_changed = i_level != r_last;
    always_comb begin
        case (i_cfg.mode)
            MODE_ANY:  w_edge_ok = 1'b1;
            MODE_FALL: w_edge_ok = !i_level;
            MODE_RISE: w_edge_ok = i_level;
            default:   w_edge_ok = 1'b0;
        endcase
    end

    // Elapsed time wraps; the compare is one bit wider so neither side wraps.
    assign w_elapsed   = i_now_us - r_start;
    assign w_hold_done = ({1'b0, w_elapsed} + SLACK_US) >= {1'b0, i_cfg.need_us};

    // Next-state logic for one sample transaction.
    always_comb begin
        n_last  = r_last;
        n_armed = r_armed;
        n_start = r_start;
        o_fire  = 1'b0;
        if (i_accept && (i_cfg.mode != MODE_OFF)) begin
            if (i_cfg.need_us == '0) begin
                if (w_changed) begin
                    n_last = i_level;
                    o_fire = w_edge_ok;
                end
            end else if (w_changed) begin
                n_armed = w_edge_ok;
                if (w_edge_ok) begin
                    n_start = i_now_us;
                end
                n_last = i_level;
            end else if (r_armed && w_hold_done) begin
                o_fire  = 1'b1;
                n_armed = 1'b0;
            end
        end
    end

    // Control state resets; the start time is only read while armed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b1;
            r_armed <= 1'b0;
        end else begin
            r_last  <= n_last;
            r_armed <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

endmodule

// ----- sv/dehq_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dehq_merge
// Collects the lane fire bits into one mask per transaction and holds it in
// an output register backed by a skid register.
// ----------------------------------------------------------------------------
module dehq_merge
    import dehq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [FIRE_W-1:0] i_lane_fire,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [FIRE_W-1:0] o_fire_mask
);

    logic              r_out_valid;
    logic [FIRE_W-1:0] r_out_mask;
    logic              r_skid_valid;
    logic [FIRE_W-1:0] r_skid_mask;

    // Input side stalls only when both stages hold a result.
    assign o_ready     = !r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_fire_mask = r_out_mask;

    // Output register and skid control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= i_accept;
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result data.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out_mask <= r_skid_mask;
            end
        end else if (!r_out_valid || i_ready) begin
            r_out_mask <= i_lane_fire;
        end else if (i_accept) begin
            r_skid_mask <= i_lane_fire;
        end
    end

endmodule

// ----- sv/din_edge_event_hold_qualifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// din_edge_event_hold_qualifier
// Digital input edge event detector with per-port hold time.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is one poll sample (port levels plus a
// free-running microsecond time) and yields exactly one fire mask, presented
// on the output channel the cycle after acceptance unless the output stalls.
// A new sample is taken every cycle: the per-port lanes update their arm state
// and evaluate the hold-time compare (wrapping subtract, add of the slack,
// 33-bit compare) combinationally; the output register plus a skid register
// let the input keep flowing while a mask waits, so ready drops only when two
// masks are queued. Hold times are scaled to microseconds on register write.
// ----------------------------------------------------------------------------
module din_edge_event_hold_qualifier
    import dehq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Sample channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [FIRE_W-1:0]    i_levels,
    input  logic [TIME_W-1:0]    i_now_us,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FIRE_W-1:0]    o_fire_mask,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [HOLD_W-1:0]    i_cfg_data
);

    logic [MODES_W-1:0] r_port_modes;
    logic [TIME_W-1:0]  r_need_us [FIRE_W];
    logic [TIME_W-1:0]  n_need_us;
    logic [1:0]         w_hold_sel;
    logic               w_cfg_wr;
    logic               w_accept;
    logic [FIRE_W-1:0]  w_lane_fire;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_hold_sel  = 2'(i_cfg_index - CFG_HOLD_PORT0);
    assign n_need_us   = TIME_W'({{(TIME_W-HOLD_W){1'b0}}, i_cfg_data} * US_PER_MS);

    // Register file: mode byte and hold times stored in microseconds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_modes <= '0;
            for (int p = 0; p < FIRE_W; p++) begin
                r_need_us[p] <= '0;
            end
        end else if (w_cfg_wr) begin
            case (i_cfg_index) inside
                CFG_PORT_MODES: begin
                    r_port_modes <= i_cfg_data[MODES_W-1:0];
                end
                [CFG_HOLD_PORT0:CFG_HOLD_PORT3]: begin
                    r_need_us[w_hold_sel] <= n_need_us;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_accept = i_in_valid && o_in_ready;

    // One lane per port; unused mask bits stay low.
    for (genvar p = 0; p < FIRE_W; p++) begin : g_lane
        if (p < NUM_PORTS) begin : g_used
            t_lane_cfg w_cfg;
            assign w_cfg.mode    = t_mode'(r_port_modes[2*p +: 2]);
            assign w_cfg.need_us = r_need_us[p];

            dehq_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_accept (w_accept),
                .i_cfg    (w_cfg),
                .i_level  (i_levels[p]),
                .i_now_us (i_now_us),
                .o_fire   (w_lane_fire[p])
            );
        end else begin : g_unused
            assign w_lane_fire[p] = 1'b0;
        end
    end

    // Merge lane results into the registered fire mask.
    dehq_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_lane_fire (w_lane_fire),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_fire_mask (o_fire_mask)
    );

endmodule

// ----- tb/sv/din_edge_event_hold_qualifier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// din_edge_event_hold_qualifier_tb
// Self-checking testbench for the digital input edge event qualifier.
// ----------------------------------------------------------------------------
// A scoreboard class tracks port levels, arm state and start times from every
// accepted sample and queues the fire mask each one should produce. Results
// are compared in order as they leave the block. A short directed sequence
// covers immediate edges, time wrap, hold thresholds at their exact edges and
// settings changed while armed. Random phases with fresh settings follow.
// Sender bursts, receiver stall patterns and long receiver hold-offs vary the
// flow control throughout.
// ----------------------------------------------------------------------------
module din_edge_event_hold_qualifier_tb;
    import dehq_pkg::*;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS = 2'd0,
        RX_HALF   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_PULSED = 2'd3
    } t_rx_pattern;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // Scoreboard: predicts the fire mask of each sample and checks results.
    class edge_event_tracker;
        logic [MODES_W-1:0] modes;
        logic [HOLD_W-1:0]  hold_ms [NUM_PORTS];
        logic               last_level [NUM_PORTS];
        logic               armed [NUM_PORTS];
        logic [TIME_W-1:0]  start_us [NUM_PORTS];
        logic [FIRE_W-1:0]  expected_masks [$];
        int                 errors;

        function new();
            modes  = '0;
            errors = 0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                hold_ms[p]    = '0;
                last_level[p] = 1'b1;
                armed[p]      = 1'b0;
                start_us[p]   = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] data);
            if (idx == CFG_PORT_MODES) begin
                modes = data[MODES_W-1:0];
            end else if (idx >= CFG_HOLD_PORT0 && idx <= CFG_HOLD_PORT3) begin
                hold_ms[idx - CFG_HOLD_PORT0] = data;
            end
        endfunction

        function bit edge_wanted(t_mode m, logic lvl);
            return (m == MODE_ANY) || (m == MODE_FALL && !lvl) || (m == MODE_RISE && lvl);
        endfunction

        // Advance the per-port state by one sample and queue its fire mask.
        function void note_sample(logic [FIRE_W-1:0] levels, logic [TIME_W-1:0] now);
            logic [FIRE_W-1:0] fire;
            t_mode             m;
            logic              lvl;
            logic [TIME_W-1:0] elapsed;
            logic [63:0]       need;
            logic [63:0]       reach;
            fire = '0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                m   = t_mode'(modes[2*p +: 2]);
                lvl = levels[p];
                if (m != MODE_OFF) begin
                    if (hold_ms[p] == '0) begin
                        if (lvl != last_level[p]) begin
                            last_level[p] = lvl;
                            if (edge_wanted(m, lvl)) fire[p] = 1'b1;
                        end
                    end else if (lvl != last_level[p]) begin
                        if (edge_wanted(m, lvl)) begin
                            armed[p]    = 1'b1;
                            start_us[p] = now;
                        end else begin
                            armed[p] = 1'b0;
                        end
                        last_level[p] = lvl;
                    end else if (armed[p]) begin
                        elapsed = now - start_us[p];
                        need    = 64'(hold_ms[p]) * 64'(US_PER_MS);
                        reach   = 64'(elapsed) + 64'(SLACK_US);
                        if (reach >= need) begin
                            fire[p]  = 1'b1;
                            armed[p] = 1'b0;
                        end
                    end
                end
            end
            expected_masks.push_back(fire);
        endfunction

        function void check_mask(logic [FIRE_W-1:0] mask);
            logic [FIRE_W-1:0] want;
            if (expected_masks.size() == 0) begin
                $error("fire_mask: expected none, actual %h", mask);
                errors++;
            end else begin
                want = expected_masks.pop_front();
                if (mask !== want) begin
                    $error("fire_mask: expected %h, actual %h", want, mask);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [FIRE_W-1:0]    i_levels    = '0;
    logic [TIME_W-1:0]    i_now_us    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [FIRE_W-1:0]    o_fire_mask;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [HOLD_W-1:0]    i_cfg_data  = '0;

    edge_event_tracker tracker = new();

    // Receiver flow-control state.
    t_rx_pattern rx_pattern    = RX_ALWAYS;
    int          rx_left       = 0;
    int          hold_off_left = 0;
    int          hold_off_reqs = 0;
    int          hold_off_seen = 0;

    din_edge_event_hold_qualifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_levels    (i_levels),
        .i_now_us    (i_now_us),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_fire_mask (o_fire_mask),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Monitor: every transaction on the three channels goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) tracker.check_mask(o_fire_mask);
            if (i_in_valid && o_in_ready) tracker.note_sample(i_levels, i_now_us);
            if (i_cfg_valid && o_cfg_ready) tracker.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // Receiver: a changing stall pattern, overridden by long hold-offs on request.
    always @(negedge i_clk) begin
        if (hold_off_seen != hold_off_reqs) begin
            hold_off_seen = hold_off_reqs;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (rx_left == 0) begin
            rx_pattern = t_rx_pattern'($urandom_range(0, 3));
            rx_left    = $urandom_range(10, 200);
        end else begin
            rx_left--;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_out_ready = 1'b0;
        end else begin
            case (rx_pattern)
                RX_ALWAYS: i_out_ready = 1'b1;
                RX_HALF:   i_out_ready = 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready = ($urandom_range(0, 3) == 0);
                default:   i_out_ready = rx_left[2];
            endcase
        end
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("din_edge_event_hold_qualifier: mismatch");
        $finish;
    end

    // Offer one sample and hold it until the block takes it.
    task automatic send_sample(logic [FIRE_W-1:0] levels, logic [TIME_W-1:0] now);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_levels   = levels;
        i_now_us   = now;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Leave the sample channel idle for a number of cycles.
    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stop offering samples and wait until every fire mask has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    function automatic logic [HOLD_W-1:0] pick_hold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return HOLD_W'($urandom_range(1, 24));
            2:       return HOLD_W'($urandom_range(25, 120));
            3:       return HOLD_W'($urandom_range(121, 5000));
            4:       return HOLD_W'(3600000);
            default: return HOLD_W'($urandom_range(0, 4194303));
        endcase
    endfunction

    // Time advance between samples: mostly short, sometimes long or arbitrary.
    function automatic logic [TIME_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return TIME_W'($urandom_range(0, 3000));
        if (r < 90) return TIME_W'($urandom_range(0, 200000));
        return TIME_W'($urandom);
    endfunction

    initial begin
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] cur_now;
        logic [FIRE_W-1:0] cur_levels;
        logic [MODES_W-1:0] modes;
        int items;
        int gap_max;
        int toggle_rate;
        int burst_left;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Immediate edges: port 0 falling, port 1 rising, port 2 any, port 3 off.
        cfg_write(CFG_PORT_MODES, HOLD_W'({MODE_OFF, MODE_ANY, MODE_RISE, MODE_FALL}));
        send_sample(4'hF, 32'd0);
        send_sample(4'h0, 32'd1);
        send_sample(4'hF, 32'd2);
        send_sample(4'h0, 32'd3);
        send_sample(4'h5, 32'd4);
        send_sample(4'hA, 32'd5);
        wait_drained();

        // Hold thresholds at their exact edges, with the time wrapping.
        cfg_write(CFG_PORT_MODES, 22'h3FFFFF);
        cfg_write(CFG_HOLD_PORT0, 22'd30);
        cfg_write(CFG_HOLD_PORT0 + 3'd1, 22'd1);
        cfg_write(CFG_HOLD_PORT0 + 3'd2, 22'd3600000);
        cfg_write(CFG_HOLD_PORT3, HOLD_MAX);
        t0 = 32'hFFFF_F000;
        send_sample(4'hF, t0);
        send_sample(4'h0, t0);
        send_sample(4'h0, t0 + 32'd1000);
        send_sample(4'h0, t0 + 32'd5999);
        send_sample(4'h0, t0 + 32'd6000);
        send_sample(4'h0, t0 + 32'd3599975999);
        send_sample(4'h0, t0 + 32'd3599976000);
        send_sample(4'h0, t0 + 32'd4194278999);
        send_sample(4'h0, t0 + 32'd4194279000);
        send_sample(4'h0, 32'hFFFF_FFFF);
        send_sample(4'hF, 32'hFFFF_FFFF);
        send_sample(4'h0, 32'd10);
        wait_drained();

        // Port turned off while armed keeps its state; the others see falls only.
        cfg_write(CFG_PORT_MODES, HOLD_W'({MODE_FALL, MODE_FALL, MODE_FALL, MODE_OFF}));
        send_sample(4'hE, 32'd20);
        send_sample(4'h0, 32'd30000);
        wait_drained();
        cfg_write(CFG_PORT_MODES, 22'h0000FF);
        send_sample(4'h0, 32'd40000);
        wait_drained();

        // Random phases, each with fresh settings.
        cur_now    = 32'd40000;
        cur_levels = 4'h0;
        burst_left = 0;
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            items       = (ph == 1) ? 40 : 180;
            gap_max     = (ph % 3 == 0) ? 0 : 6;
            toggle_rate = $urandom_range(4, 40);
            modes       = MODES_W'($urandom);
            if (ph == 0) modes = '1;
            if (ph == 1) modes = '0;
            cfg_write(CFG_PORT_MODES, {HOLD_W'($urandom)} & ~HOLD_W'(8'hFF) | HOLD_W'(modes));
            for (int p = 0; p < NUM_PORTS; p++) begin
                if (ph == 0) cfg_write(CFG_HOLD_PORT0 + 3'(p), '0);
                else if (ph == 5) cfg_write(CFG_HOLD_PORT0 + 3'(p), HOLD_MAX);
                else cfg_write(CFG_HOLD_PORT0 + 3'(p), pick_hold());
            end
            // Writes to indexes past the register list must change nothing.
            if (ph == 3) begin
                for (int k = 1; k <= 3; k++) begin
                    cfg_write(CFG_HOLD_PORT3 + 3'(k), HOLD_W'($urandom));
                end
            end
            if (ph == 2 || ph == 6) hold_off_reqs++;

            for (int n = 0; n < items; n++) begin
                if (burst_left == 0) begin
                    idle_gap($urandom_range(0, gap_max));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if ($urandom_range(0, 9) == 0) begin
                    cur_levels = FIRE_W'($urandom);
                end else begin
                    for (int p = 0; p < NUM_PORTS; p++) begin
                        if ($urandom_range(0, toggle_rate - 1) == 0) cur_levels[p] = ~cur_levels[p];
                    end
                end
                cur_now = cur_now + pick_step();
                send_sample(cur_levels, cur_now);
            end
        end

        // Drain and report.
        wait_drained();
        repeat (5) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("din_edge_event_hold_qualifier: match");
        end else begin
            $display("din_edge_event_hold_qualifier: mismatch");
        end
        $finish;
    end

endmodule
